// ===== hw/rtl/rlpe_pkg.sv =====
package rlpe_pkg;

   // field widths
   localparam int CHAN_W = 8;
   localparam int TIME_W = 16;
   localparam int CHAN_N = 3;
   localparam int PROD_W = 2 * CHAN_W;

   // pattern codes
   typedef enum logic [1:0] {
      PAT_OFF   = 2'd0,
      PAT_SOLID = 2'd1,
      PAT_BLINK = 2'd2,
      PAT_FADE  = 2'd3
   } pattern_type;

   // item kinds carried on tuser
   localparam logic OP_CMD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // register indexes
   localparam logic [1:0] REG_TRANSITION = 2'd0;
   localparam logic [1:0] REG_FADE_CYCLE = 2'd1;
   localparam logic [1:0] REG_BLINK      = 2'd2;

   // register reset values
   localparam logic [TIME_W-1:0] TRANSITION_RST = 16'd300;
   localparam logic [TIME_W-1:0] FADE_CYCLE_RST = 16'd2048;
   localparam logic [TIME_W-1:0] BLINK_RST      = 16'd500;

   // colour and phase constants
   localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;
   localparam logic [CHAN_W-1:0] HALF_PHASE   = 8'd128;
   localparam logic [CHAN_W-1:0] BREATH_START = 8'd64;
   localparam logic [TIME_W-1:0] ELAPSED_MAX  = 16'hFFFF;

   // status of a bit-serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // exact x / 255 for any x up to 255 * 255, the product of two 8-bit values
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] sum;
      sum = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
      return sum[PROD_W-1:CHAN_W];
   endfunction

endpackage

// ===== hw/rtl/rlpe_div.sv =====
module rlpe_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rlpe_pkg::TIME_W-1:0]  elapsed,
   input  logic [rlpe_pkg::TIME_W-1:0]  divisor,
   output logic [rlpe_pkg::CHAN_W-1:0]  quot,
   output rlpe_pkg::unit_stat_type      stat
);
   import rlpe_pkg::*;

   localparam int DIVIDEND_W = TIME_W + CHAN_W;

   logic [DIVIDEND_W-1:0] dividend;
   logic [TIME_W+1:0]     trial;
   logic                  borrow;

   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [CHAN_W-1:0] low_ff, low_in;
   logic [CHAN_W-1:0] quot_ff, quot_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // elapsed * 255 as a shift and subtract
   assign dividend = {elapsed, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, elapsed};

   // one restoring step: the quotient fits in 8 bits, so the top 16 bits start as remainder
   assign trial  = {1'b0, rem_ff, low_ff[CHAN_W-1]} - {2'b00, divisor};
   assign borrow = trial[TIME_W+1];

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[DIVIDEND_W-1:CHAN_W];
         low_in  = dividend[CHAN_W-1:0];
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = borrow ? {rem_ff[TIME_W-2:0], low_ff[CHAN_W-1]} : trial[TIME_W-1:0];
         low_in  = {low_ff[CHAN_W-2:0], 1'b0};
         quot_in = {quot_ff[CHAN_W-2:0], ~borrow};
         cnt_in  = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 3'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign quot      = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== hw/rtl/rlpe_mul.sv =====
module rlpe_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rlpe_pkg::CHAN_W-1:0]  mcand,
   input  logic [rlpe_pkg::CHAN_W-1:0]  mplier,
   output logic [rlpe_pkg::PROD_W-1:0]  prod,
   output rlpe_pkg::unit_stat_type      stat
);
   import rlpe_pkg::*;

   logic [CHAN_W-1:0] a_ff, a_in;
   logic [CHAN_W-1:0] b_ff, b_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // shift-add, multiplier bits taken msb first
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = mcand;
         b_in    = mplier;
         acc_in  = '0;
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0} +
                  (b_ff[CHAN_W-1] ? {{CHAN_W{1'b0}}, a_ff} : {PROD_W{1'b0}});
         b_in   = {b_ff[CHAN_W-2:0], 1'b0};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 3'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign prod      = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== hw/rtl/rgb_led_pattern_engine.sv =====
// Drives one RGB LED from a stream of items: a command (tuser 0) sets the pattern
// (off, solid, blink, breathing fade) and the colour, a tick (tuser 1) advances time
// by one millisecond. Every item returns one result with the displayed colour and a
// flag that is high while a crossfade runs. A command equal to the current goal is
// ignored; any other one starts a crossfade from the displayed colour, lasting
// transition_ms ticks, after which the pattern runs. Items are taken one at a time:
// a command or a tick that only counts passes the evaluate and output states, a
// crossfade tick or a breathing step also the unit states, and the next item can be
// taken once the result is in the output register. The long cases are two passes
// through bit-serial units: the divider (crossfade weight) and then the three multiplier
// lanes, one per colour channel, or two passes through the lanes (curve, then colour
// scale). A new item is accepted while the previous result still waits in the output
// register; a finished item whose result finds that register still full waits for it.
// The user writes registers through the csr port only while no item is in flight;
// the block itself does not enforce it. csr_ready is always high.
module rgb_led_pattern_engine (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pattern[1:0], cmd_red[9:2], cmd_green[17:10],
                                    // cmd_blue[25:18], zero[31:26]
   input  logic        req_tuser,   // op[0]
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // shown_red[7:0], shown_green[15:8], shown_blue[23:16]
   output logic        rsp_tuser,   // in_transition[0]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rlpe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_BLEND,
      ST_CURVE,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef logic [CHAN_W-1:0] chan_type;

   state_type         state_ff, state_in;
   logic              op_ff, op_in;
   pattern_type       cmd_pat_ff, cmd_pat_in;
   chan_type          cmd_col_ff [CHAN_N];
   chan_type          cmd_col_in [CHAN_N];
   pattern_type       goal_pat_ff, goal_pat_in;
   chan_type          goal_ff [CHAN_N];
   chan_type          goal_in [CHAN_N];
   chan_type          start_ff [CHAN_N];
   chan_type          start_in [CHAN_N];
   chan_type          shown_ff [CHAN_N];
   chan_type          shown_in [CHAN_N];
   logic              fading_ff, fading_in;
   logic              lit_ff, lit_in;
   chan_type          breath_ff, breath_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [TIME_W-1:0] trans_cfg_ff, trans_cfg_in;
   logic [TIME_W-1:0] fade_cfg_ff, fade_cfg_in;
   logic [TIME_W-1:0] blink_cfg_ff, blink_cfg_in;
   logic [CHAN_N-1:0] up_ff, up_in;
   chan_type          mul_a_ff [CHAN_N];
   chan_type          mul_a_in [CHAN_N];
   chan_type          mul_b_ff, mul_b_in;
   logic              mul_go_ff, mul_go_in;
   logic              div_go_ff, div_go_in;
   logic              rsp_valid_ff, rsp_valid_in;
   chan_type          rsp_col_ff [CHAN_N];
   chan_type          rsp_col_in [CHAN_N];
   logic              rsp_fade_ff, rsp_fade_in;

   chan_type          to_col [CHAN_N];
   chan_type          mag [CHAN_N];
   logic [CHAN_N-1:0] to_up;
   logic [PROD_W-1:0] prod [CHAN_N];
   chan_type          scaled [CHAN_N];
   unit_stat_type     mul_stat [CHAN_N];
   unit_stat_type     div_stat;
   chan_type          quot;
   chan_type          step_w;
   chan_type          breath_nx;
   chan_type          breath_inv;
   chan_type          lin;
   logic              cmd_same;

   // crossfade weight unit
   rlpe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_go_ff),
      .elapsed (elapsed_ff),
      .divisor (trans_cfg_ff),
      .quot    (quot),
      .stat    (div_stat)
   );

   // one multiplier lane per channel
   for (genvar g = 0; g < CHAN_N; g++) begin : g_lane
      rlpe_mul u_mul (
         .clock  (clock),
         .reset  (reset),
         .start  (mul_go_ff),
         .mcand  (mul_a_ff[g]),
         .mplier (mul_b_ff),
         .prod   (prod[g]),
         .stat   (mul_stat[g])
      );
      assign scaled[g] = div255(prod[g]);
   end

   // per channel crossfade target, direction and distance
   always_comb begin
      for (int i = 0; i < CHAN_N; i++) begin
         to_col[i] = (goal_pat_ff == PAT_OFF) ? '0 : goal_ff[i];
         to_up[i]  = (to_col[i] >= start_ff[i]);
         mag[i]    = to_up[i] ? (to_col[i] - start_ff[i]) : (start_ff[i] - to_col[i]);
      end
   end

   // breathing step length and triangle phase
   assign step_w     = (fade_cfg_ff[TIME_W-1:CHAN_W] == '0) ? 8'd1
                                                            : fade_cfg_ff[TIME_W-1:CHAN_W];
   assign breath_nx  = breath_ff + 8'd1;
   assign breath_inv = ~breath_nx;
   assign lin        = (breath_nx < HALF_PHASE) ? {breath_nx[CHAN_W-2:0], 1'b0}
                                                : {breath_inv[CHAN_W-2:0], 1'b0};

   assign cmd_same = (cmd_pat_ff == goal_pat_ff) && (cmd_col_ff[0] == goal_ff[0]) &&
                     (cmd_col_ff[1] == goal_ff[1]) && (cmd_col_ff[2] == goal_ff[2]);

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cmd_pat_in   = cmd_pat_ff;
      goal_pat_in  = goal_pat_ff;
      fading_in    = fading_ff;
      lit_in       = lit_ff;
      breath_in    = breath_ff;
      elapsed_in   = elapsed_ff;
      trans_cfg_in = trans_cfg_ff;
      fade_cfg_in  = fade_cfg_ff;
      blink_cfg_in = blink_cfg_ff;
      up_in        = up_ff;
      mul_b_in     = mul_b_ff;
      mul_go_in    = 1'b0;
      div_go_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_fade_in  = rsp_fade_ff;
      for (int i = 0; i < CHAN_N; i++) begin
         cmd_col_in[i] = cmd_col_ff[i];
         goal_in[i]    = goal_ff[i];
         start_in[i]   = start_ff[i];
         shown_in[i]   = shown_ff[i];
         mul_a_in[i]   = mul_a_ff[i];
         rsp_col_in[i] = rsp_col_ff[i];
      end

      // register writes
      if (csr_valid) begin
         case (csr_index)
            REG_TRANSITION: trans_cfg_in = csr_data;
            REG_FADE_CYCLE: fade_cfg_in  = csr_data;
            REG_BLINK:      blink_cfg_in = csr_data;
            default: ;
         endcase
      end

      // result taken downstream
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tuser;
               cmd_pat_in    = pattern_type'(req_tdata[1:0]);
               cmd_col_in[0] = req_tdata[9:2];
               cmd_col_in[1] = req_tdata[17:10];
               cmd_col_in[2] = req_tdata[25:18];
               if (req_tuser == OP_TICK && elapsed_ff != ELAPSED_MAX) begin
                  elapsed_in = elapsed_ff + 16'd1;
               end
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_OUT;
            if (op_ff == OP_CMD) begin
               // a new goal starts a crossfade from what is shown
               if (!cmd_same) begin
                  goal_pat_in = cmd_pat_ff;
                  for (int i = 0; i < CHAN_N; i++) begin
                     start_in[i] = shown_ff[i];
                     goal_in[i]  = cmd_col_ff[i];
                  end
                  elapsed_in = '0;
                  fading_in  = 1'b1;
                  lit_in     = 1'b0;
                  breath_in  = '0;
               end
            end else if (fading_ff) begin
               if (elapsed_ff >= trans_cfg_ff) begin
                  // crossfade end: enter the pattern
                  fading_in  = 1'b0;
                  elapsed_in = '0;
                  for (int i = 0; i < CHAN_N; i++) begin
                     shown_in[i] = to_col[i];
                  end
                  if (goal_pat_ff == PAT_BLINK) begin
                     lit_in = 1'b1;
                  end
                  if (goal_pat_ff == PAT_FADE) begin
                     breath_in = BREATH_START;
                  end
               end else begin
                  up_in = to_up;
                  for (int i = 0; i < CHAN_N; i++) begin
                     mul_a_in[i] = mag[i];
                  end
                  div_go_in = 1'b1;
                  state_in  = ST_DIV;
               end
            end else if (goal_pat_ff == PAT_FADE) begin
               if (elapsed_ff >= {{(TIME_W-CHAN_W){1'b0}}, step_w}) begin
                  elapsed_in  = '0;
                  breath_in   = breath_nx;
                  mul_a_in[0] = lin;
                  mul_b_in    = lin;
                  mul_go_in   = 1'b1;
                  state_in    = ST_CURVE;
               end
            end else if (goal_pat_ff == PAT_BLINK) begin
               if (elapsed_ff >= blink_cfg_ff) begin
                  elapsed_in = '0;
                  lit_in     = !lit_ff;
                  for (int i = 0; i < CHAN_N; i++) begin
                     shown_in[i] = lit_ff ? '0 : goal_ff[i];
                  end
               end
            end
         end
         ST_DIV: begin
            // weight ready, scale the distances
            if (div_stat.done) begin
               mul_b_in  = quot;
               mul_go_in = 1'b1;
               state_in  = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (mul_stat[0].done) begin
               for (int i = 0; i < CHAN_N; i++) begin
                  shown_in[i] = up_ff[i] ? (start_ff[i] + scaled[i])
                                         : (start_ff[i] - scaled[i]);
               end
               state_in = ST_OUT;
            end
         end
         ST_CURVE: begin
            // squared triangle done, now scale the goal colour by it
            if (mul_stat[0].done) begin
               for (int i = 0; i < CHAN_N; i++) begin
                  mul_a_in[i] = goal_ff[i];
               end
               mul_b_in  = scaled[0];
               mul_go_in = 1'b1;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mul_stat[0].done) begin
               for (int i = 0; i < CHAN_N; i++) begin
                  shown_in[i] = scaled[i];
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_fade_in  = fading_ff;
               for (int i = 0; i < CHAN_N; i++) begin
                  rsp_col_in[i] = shown_ff[i];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         goal_pat_ff  <= PAT_OFF;
         fading_ff    <= 1'b0;
         lit_ff       <= 1'b0;
         breath_ff    <= '0;
         elapsed_ff   <= '0;
         trans_cfg_ff <= TRANSITION_RST;
         fade_cfg_ff  <= FADE_CYCLE_RST;
         blink_cfg_ff <= BLINK_RST;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHAN_N; i++) begin
            goal_ff[i]  <= '0;
            start_ff[i] <= '0;
            shown_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         goal_pat_ff  <= goal_pat_in;
         fading_ff    <= fading_in;
         lit_ff       <= lit_in;
         breath_ff    <= breath_in;
         elapsed_ff   <= elapsed_in;
         trans_cfg_ff <= trans_cfg_in;
         fade_cfg_ff  <= fade_cfg_in;
         blink_cfg_ff <= blink_cfg_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < CHAN_N; i++) begin
            goal_ff[i]  <= goal_in[i];
            start_ff[i] <= start_in[i];
            shown_ff[i] <= shown_in[i];
         end
      end
      op_ff       <= op_in;
      cmd_pat_ff  <= cmd_pat_in;
      up_ff       <= up_in;
      mul_b_ff    <= mul_b_in;
      rsp_fade_ff <= rsp_fade_in;
      for (int i = 0; i < CHAN_N; i++) begin
         cmd_col_ff[i] <= cmd_col_in[i];
         mul_a_ff[i]   <= mul_a_in[i];
         rsp_col_ff[i] <= rsp_col_in[i];
      end
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff[2], rsp_col_ff[1], rsp_col_ff[0]};
   assign rsp_tuser  = rsp_fade_ff;

   // one item in flight at a time
   a_single_item : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in flight");

   // divider and multiplier lanes never overlap
   a_units_apart : assert property (@(posedge clock) disable iff (reset)
      !(div_stat.busy && mul_stat[0].busy))
      else $error("divider and multiplier busy together");

   // weight and blend only run during a crossfade
   a_blend_fading : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_BLEND) |-> fading_ff)
      else $error("blend step outside a crossfade");

   // crossfade end restarts the tick count
   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      $fell(fading_ff) |-> (elapsed_ff == '0))
      else $error("tick count not cleared at crossfade end");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import rlpe_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 32;
   // index with no register behind it, writes are dropped
   localparam logic [1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic        op;
      pattern_type pat;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } lamp_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       fading;
   } led_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   rgb_led_pattern_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // timing registers as the block should hold them
   logic [15:0] trans_len = TRANSITION_RST;
   logic [15:0] fade_cycle = FADE_CYCLE_RST;
   logic [15:0] blink_len = BLINK_RST;

   // led state
   pattern_type goal_pat = PAT_OFF;
   logic [7:0]  goal_rgb [CHAN_N] = '{default: '0};
   logic [7:0]  start_rgb [CHAN_N] = '{default: '0};
   logic [7:0]  shown_rgb [CHAN_N] = '{default: '0};
   logic        fading = 1'b0;
   logic        blink_on = 1'b0;
   logic [7:0]  breath = '0;
   logic [15:0] ms_count = '0;

   led_view_type pending_colours [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;

   // crossfade of one channel, quotient truncated toward zero
   function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                             input int unsigned w);
      int unsigned ua, ub;
      ua = 32'(a);
      ub = 32'(b);
      if (ub >= ua)
         return 8'(ua + ((ub - ua) * w) / 255);
      return 8'(ua - ((ua - ub) * w) / 255);
   endfunction

   // squared triangle over the 8-bit breathing phase
   function automatic int unsigned breath_curve(input logic [7:0] phase);
      int unsigned p, lin;
      p = 32'(phase);
      lin = (p < HALF_PHASE) ? p * 2 : (255 - p) * 2;
      return (lin * lin) / 255;
   endfunction

   function automatic void scale_goal(input int unsigned s);
      for (int i = 0; i < CHAN_N; i++)
         shown_rgb[i] = 8'((32'(goal_rgb[i]) * s) / 255);
   endfunction

   // advance the led state by one item, return the colour shown afterwards
   function automatic led_view_type update_display(input lamp_item_type it);
      int unsigned  w, step, dest;
      led_view_type view;
      if (it.op == OP_TICK) begin
         if (ms_count != ELAPSED_MAX)
            ms_count = ms_count + 1'b1;
         if (fading) begin
            if (ms_count >= trans_len) begin
               fading = 1'b0;
               ms_count = '0;
               scale_goal((goal_pat == PAT_OFF) ? 0 : 255);
               if (goal_pat == PAT_BLINK)
                  blink_on = 1'b1;
               else if (goal_pat == PAT_FADE)
                  breath = BREATH_START;
            end else begin
               w = (int'(ms_count) * 255) / int'(trans_len);
               for (int i = 0; i < CHAN_N; i++) begin
                  dest = (goal_pat == PAT_OFF) ? 0 : goal_rgb[i];
                  shown_rgb[i] = blend_chan(start_rgb[i], dest[7:0], w);
               end
            end
         end else if (goal_pat == PAT_FADE) begin
            step = 32'(fade_cycle >> 8);
            if (step < 1)
               step = 1;
            if (ms_count >= step) begin
               ms_count = '0;
               breath = breath + 1'b1;
               scale_goal(breath_curve(breath));
            end
         end else if (goal_pat == PAT_BLINK) begin
            if (ms_count >= blink_len) begin
               ms_count = '0;
               blink_on = !blink_on;
               scale_goal(blink_on ? 255 : 0);
            end
         end
      end else if (it.pat != goal_pat || it.red != goal_rgb[0] || it.green != goal_rgb[1]
                   || it.blue != goal_rgb[2]) begin
         // new goal: crossfade starts from what is shown now
         start_rgb = shown_rgb;
         goal_pat = it.pat;
         goal_rgb[0] = it.red;
         goal_rgb[1] = it.green;
         goal_rgb[2] = it.blue;
         ms_count = '0;
         fading = 1'b1;
         blink_on = 1'b0;
         breath = '0;
      end
      view.red = shown_rgb[0];
      view.green = shown_rgb[1];
      view.blue = shown_rgb[2];
      view.fading = fading;
      return view;
   endfunction

   function automatic void log_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("mismatch %0d: %s", error_count, msg);
   endfunction

   // result checker
   always @(posedge clock) begin
      led_view_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red = rsp_tdata[7:0];
         got.green = rsp_tdata[15:8];
         got.blue = rsp_tdata[23:16];
         got.fading = rsp_tuser;
         if (pending_colours.size() == 0) begin
            log_error($sformatf("unexpected result %02h %02h %02h fading %0b",
                                got.red, got.green, got.blue, got.fading));
         end else begin
            want = pending_colours.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
                || got.fading !== want.fading)
               log_error($sformatf({"expected %02h %02h %02h fading %0b, ",
                                    "got %02h %02h %02h fading %0b"},
                                   want.red, want.green, want.blue, want.fading,
                                   got.red, got.green, got.blue, got.fading));
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one item on the input stream, with random idle cycles ahead of it
   task automatic send_item(input lamp_item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, it.blue, it.green, it.red, it.pat};
      req_tuser <= it.op;
      do @(posedge clock); while (!req_tready);
      pending_colours.push_back(update_display(it));
   endtask

   // stop sending and let every result come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_colours.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_one(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_TRANSITION: trans_len = val;
         REG_FADE_CYCLE: fade_cycle = val;
         REG_BLINK:      blink_len = val;
         default:        ;
      endcase
   endtask

   // all timing registers in one burst, block must be idle
   task automatic load_timing(input logic [15:0] trans, input logic [15:0] fcycle,
                              input logic [15:0] blink);
      write_one(REG_TRANSITION, trans);
      write_one(REG_FADE_CYCLE, fcycle);
      write_one(REG_BLINK, blink);
      write_one(REG_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic lamp_item_type make_command(input pattern_type p, input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b);
      lamp_item_type it;
      it.op = OP_CMD;
      it.pat = p;
      it.red = r;
      it.green = g;
      it.blue = b;
      return it;
   endfunction

   function automatic logic [7:0] random_level();
      int unsigned pick;
      pick = $urandom_range(7);
      if (pick == 0)
         return 8'd0;
      if (pick == 1)
         return CHAN_MAX;
      return 8'($urandom_range(255));
   endfunction

   // ticks carry random junk in the command fields
   function automatic lamp_item_type random_tick();
      lamp_item_type it;
      it = make_command(pattern_type'($urandom_range(3)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)));
      it.op = OP_TICK;
      return it;
   endfunction

   // mostly new goals, some repeats of the current one
   function automatic lamp_item_type random_command();
      if ($urandom_range(99) < 15)
         return make_command(goal_pat, goal_rgb[0], goal_rgb[1], goal_rgb[2]);
      return make_command(pattern_type'($urandom_range(3)), random_level(), random_level(),
                          random_level());
   endfunction

   task automatic send_ticks(input int n);
      repeat (n) send_item(random_tick());
   endtask

   // every pattern, repeated goal, zero lengths, black and full colours
   task automatic test_directed();
      send_item(make_command(PAT_OFF, 8'd0, 8'd0, 8'd0));
      send_ticks(1);
      send_item(make_command(PAT_SOLID, CHAN_MAX, CHAN_MAX, CHAN_MAX));
      send_ticks(2);
      wait_idle();
      load_timing(16'd2, 16'd0, 16'd0);
      send_item(make_command(PAT_SOLID, CHAN_MAX, CHAN_MAX, CHAN_MAX));
      send_ticks(1);
      send_item(make_command(PAT_SOLID, CHAN_MAX, CHAN_MAX, CHAN_MAX));
      send_item(make_command(PAT_BLINK, CHAN_MAX, 8'd0, CHAN_MAX));
      send_ticks(4);
      send_item(make_command(PAT_FADE, 8'd0, CHAN_MAX, HALF_PHASE));
      send_ticks(4);
      send_item(make_command(PAT_OFF, HALF_PHASE, HALF_PHASE, HALF_PHASE));
      send_ticks(2);
      wait_idle();
      load_timing(16'd0, 16'd255, 16'd1);
      send_item(make_command(PAT_SOLID, 8'd1, 8'd2, 8'd3));
      send_ticks(1);
      send_item(make_command(PAT_BLINK, 8'd0, 8'd0, 8'd0));
      send_ticks(3);
   endtask

   // breathing phase runs past 255 and wraps
   task automatic test_fade_wrap();
      wait_idle();
      load_timing(16'd1, 16'd256, 16'd3);
      send_item(make_command(PAT_FADE, random_level(), random_level(), random_level()));
      send_ticks(200);
   endtask

   // largest lengths, then a single-tick crossfade into slow patterns
   task automatic test_timing_extremes();
      wait_idle();
      load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(make_command(PAT_SOLID, random_level(), random_level(), random_level()));
      send_ticks(6);
      send_item(make_command(PAT_FADE, random_level(), random_level(), random_level()));
      send_ticks(4);
      wait_idle();
      load_timing(16'd1, 16'hFFFF, 16'hFFFF);
      send_item(make_command(PAT_FADE, random_level(), random_level(), random_level()));
      send_ticks(6);
      send_item(make_command(PAT_BLINK, random_level(), random_level(), random_level()));
      send_ticks(4);
   endtask

   // commands followed by bursts of ticks, short timing so patterns get reached
   task automatic test_random_traffic(input int send_pct, input int stall_pct);
      int sent, burst;
      logic [15:0] trans;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (2) begin
         wait_idle();
         case ($urandom_range(9))
            0:       trans = 16'd0;
            1:       trans = 16'd1;
            default: trans = 16'($urandom_range(12, 2));
         endcase
         load_timing(trans, 16'($urandom_range(2000)), 16'($urandom_range(8)));
         sent = 0;
         while (sent < 50) begin
            send_item(random_command());
            burst = $urandom_range(14);
            send_ticks(burst);
            sent += burst + 1;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fade_wrap();
      test_timing_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(52, 0);
      test_random_traffic(0, 52);
      test_random_traffic(30, 30);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_idle();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
